// ===== rtl/assert_macros.svh =====
// Assertion helper macros used by the core top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ptlfo_pkg.sv =====
// Shared types, constants and tables of the trapezoid LFO core.
package ptlfo_pkg;

  localparam int CHAN_W  = 4;
  localparam int CV_W    = 15;
  localparam int LEVEL_W = 15;
  localparam int IDX_W   = 3;
  localparam int CFG_W   = 25;

  typedef enum logic [IDX_W-1:0] {
    REG_BASE_RATE   = 3'd0,
    REG_CV_GAIN     = 3'd1,
    REG_WAVE_SCALE  = 3'd2,
    REG_WAVE_OFFSET = 3'd3,
    REG_HZ_STEP     = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [14:0] base_rate;
    logic signed [15:0] cv_gain;
    logic        [16:0] wave_scale;
    logic signed [15:0] wave_offset;
    logic        [24:0] hz_step;
  } cfg_t;

  localparam logic signed [14:0] BASE_RATE_RST   = 15'sd1024;
  localparam logic signed [15:0] CV_GAIN_RST     = 16'sd0;
  localparam logic        [16:0] WAVE_SCALE_RST  = 17'd65536;
  localparam logic signed [15:0] WAVE_OFFSET_RST = 16'sd0;
  localparam logic        [24:0] HZ_STEP_RST     = 25'd89478;

  typedef enum logic [3:0] {
    OP_NONE   = 4'd0,
    OP_PITCH  = 4'd1,
    OP_CLAMP  = 4'd2,
    OP_HORNER = 4'd3,
    OP_INC    = 4'd4,
    OP_SHIFT  = 4'd5,
    OP_PHASE  = 4'd6,
    OP_TRI    = 4'd7,
    OP_MIX    = 4'd8,
    OP_SCALE  = 4'd9,
    OP_LEVEL  = 4'd10
  } op_t;

  typedef struct packed {
    logic       load;      // capture input word, read phase memory
    op_t        op;
    logic [2:0] coef_sel;
    logic       out_load;  // move result into output register
  } cmd_t;

  typedef struct packed {
    logic chan_oor;
  } status_t;

  localparam logic [2:0] HORNER_LAST = 3'd5;

  localparam logic signed [16:0] PITCH_MAX  = 17'sd20480;
  localparam logic signed [16:0] PITCH_MIN  = -17'sd20480;
  localparam logic        [31:0] HALF_CYCLE = 32'h8000_0000;
  localparam logic signed [34:0] SQ_TERM    = 35'sd1288503296;  // 19661 << 16
  localparam logic signed [33:0] TRI_GAIN   = 34'sd45875;
  localparam logic signed [34:0] MIX_ROUND  = 35'sd32768;
  localparam logic signed [23:0] LVL_MAX    = 24'sd16383;
  localparam logic signed [23:0] LVL_MIN    = -24'sd16384;

  // Q1.30 polynomial coefficients of 2^x, highest order first; last step adds 1.0
  function automatic logic [30:0] horner_coef(input logic [2:0] sel);
    logic [30:0] c;
    case (sel)
      3'd0:    c = 31'd2016026;
      3'd1:    c = 31'd9652230;
      3'd2:    c = 31'd59943043;
      3'd3:    c = 31'd257862976;
      3'd4:    c = 31'd744267442;
      3'd5:    c = 31'd1073741824;
      default: c = 31'd0;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/poly_trapezoid_lfo_core.sv =====
// Top level of the polyphonic trapezoid LFO: config registers, output register.
// Each input word is one sample tick for one channel; it returns one output
// word with that channel's level, 0.3 square plus 0.7 quarter-shifted triangle,
// scaled, offset and times five, in 1/1024 V. An in-range channel is worked
// through in steps, and no new word is taken until its result is loaded: the
// pitch multiply, five multiplies for the 2^x mantissa polynomial on a single
// multiplier, then the increment, phase and waveform steps. A channel at or
// above NUM_CHANNELS skips from the pitch step to the done state, returns
// level zero and leaves all phases alone.
// The next input word is taken while a result still waits in the output
// register. Phases live in a NUM_CHANNELS-entry memory with a valid bit per
// entry cleared by reset, so there is no clearing pass. Config writes are taken
// every cycle and must only happen while the core is idle.
`include "assert_macros.svh"

module poly_trapezoid_lfo_core
  import ptlfo_pkg::*;
#(
  parameter int NUM_CHANNELS = 16,
  parameter int PHASE_BITS   = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [23:0]      s_tdata,    // chan[3:0], rate_cv[18:4], zero pad
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [23:0]      m_tdata,    // out_chan[3:0], out_level[18:4], zero pad
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  cfg_t                      cfg;
  cmd_t                      cmd;
  status_t                   status;
  logic                      out_busy;
  logic [CHAN_W-1:0]         res_chan;
  logic signed [LEVEL_W-1:0] res_level;

  assign cfg_ready = 1'b1;
  assign out_busy  = m_tvalid && !m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_rate   <= BASE_RATE_RST;
      cfg.cv_gain     <= CV_GAIN_RST;
      cfg.wave_scale  <= WAVE_SCALE_RST;
      cfg.wave_offset <= WAVE_OFFSET_RST;
      cfg.hz_step     <= HZ_STEP_RST;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_BASE_RATE:   cfg.base_rate   <= cfg_data[14:0];
        REG_CV_GAIN:     cfg.cv_gain     <= cfg_data[15:0];
        REG_WAVE_SCALE:  cfg.wave_scale  <= cfg_data[16:0];
        REG_WAVE_OFFSET: cfg.wave_offset <= cfg_data[15:0];
        REG_HZ_STEP:     cfg.hz_step     <= cfg_data[24:0];
        default: begin
        end
      endcase
    end
  end

  ptlfo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .out_busy (out_busy),
    .cmd      (cmd)
  );

  ptlfo_dpath #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .PHASE_BITS   (PHASE_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg       (cfg),
    .in_chan   (s_tdata[3:0]),
    .in_cv     (s_tdata[18:4]),
    .status    (status),
    .res_chan  (res_chan),
    .res_level (res_level)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {5'd0, res_level, res_chan};
    end
  end

  `ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "input word taken while busy")
  `ASSERT_IMPLIES(a_no_overwrite, cmd.out_load, !m_tvalid || m_tready, "pending word overwritten")
  `ASSERT_IMPLIES(a_valid_from_load, $rose(m_tvalid), $past(cmd.out_load), "output valid without result")

endmodule

// ===== rtl/ptlfo_ctrl.sv =====
// Sequencing state machine of the trapezoid LFO core.
module ptlfo_ctrl
  import ptlfo_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  input  logic    out_busy,
  output cmd_t    cmd
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_PITCH  = 12'b0000_0000_0010,
    S_CLAMP  = 12'b0000_0000_0100,
    S_HORNER = 12'b0000_0000_1000,
    S_INC    = 12'b0000_0001_0000,
    S_SHIFT  = 12'b0000_0010_0000,
    S_PHASE  = 12'b0000_0100_0000,
    S_TRI    = 12'b0000_1000_0000,
    S_MIX    = 12'b0001_0000_0000,
    S_SCALE  = 12'b0010_0000_0000,
    S_LEVEL  = 12'b0100_0000_0000,
    S_DONE   = 12'b1000_0000_0000
  } state_t;

  state_t     state, state_next;
  logic [2:0] hstep, hstep_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      hstep <= 3'd0;
    end else begin
      state <= state_next;
      hstep <= hstep_next;
    end
  end

  always_comb begin
    state_next   = state;
    hstep_next   = hstep;
    in_ready     = 1'b0;
    cmd.load     = 1'b0;
    cmd.op       = OP_NONE;
    cmd.coef_sel = 3'd0;
    cmd.out_load = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PITCH;
        end
      end
      S_PITCH: begin
        // out-of-range channel skips straight to a zero result
        if (status.chan_oor) begin
          state_next = S_DONE;
        end else begin
          cmd.op     = OP_PITCH;
          state_next = S_CLAMP;
        end
      end
      S_CLAMP: begin
        cmd.op       = OP_CLAMP;
        cmd.coef_sel = 3'd0;
        hstep_next   = 3'd1;
        state_next   = S_HORNER;
      end
      S_HORNER: begin
        cmd.op       = OP_HORNER;
        cmd.coef_sel = hstep;
        if (hstep == HORNER_LAST) begin
          state_next = S_INC;
        end else begin
          hstep_next = hstep + 3'd1;
        end
      end
      S_INC: begin
        cmd.op     = OP_INC;
        state_next = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.op     = OP_SHIFT;
        state_next = S_PHASE;
      end
      S_PHASE: begin
        cmd.op     = OP_PHASE;
        state_next = S_TRI;
      end
      S_TRI: begin
        cmd.op     = OP_TRI;
        state_next = S_MIX;
      end
      S_MIX: begin
        cmd.op     = OP_MIX;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.op     = OP_SCALE;
        state_next = S_LEVEL;
      end
      S_LEVEL: begin
        cmd.op     = OP_LEVEL;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/ptlfo_dpath.sv =====
// Datapath of the trapezoid LFO core: pitch, 2^x, phase memory, waveform.
module ptlfo_dpath
  import ptlfo_pkg::*;
#(
  parameter int NUM_CHANNELS = 16,
  parameter int PHASE_BITS   = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  input  cfg_t                      cfg,
  input  logic [CHAN_W-1:0]         in_chan,
  input  logic signed [CV_W-1:0]    in_cv,
  output status_t                   status,
  output logic [CHAN_W-1:0]         res_chan,
  output logic signed [LEVEL_W-1:0] res_level
);

  localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CW = AW + CHAN_W;

  logic [PHASE_BITS-1:0] mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] vld;

  logic [CW-1:0]              chan_wide;
  logic [AW-1:0]              addr_in;
  logic [AW-1:0]              addr_q;
  logic [CHAN_W-1:0]          chan_q;
  logic signed [CV_W-1:0]     cv_q;
  logic [PHASE_BITS-1:0]      rd_phase;
  logic                       rd_vld;
  logic signed [30:0]         gprod;
  logic signed [5:0]          ip;
  logic [9:0]                 frac;
  logic [30:0]                acc;
  logic [55:0]                iprod;
  logic [PHASE_BITS-1:0]      inc;
  logic [PHASE_BITS-1:0]      phase;
  logic                       sq_neg;
  logic signed [33:0]         tri_prod;
  logic signed [17:0]         mix;
  logic signed [35:0]         sprod;
  logic signed [LEVEL_W-1:0]  level;

  // combinational step values
  logic signed [16:0]    pitch_sum, pitch_c;
  logic [40:0]           hprod;
  logic [40:0]           hround;
  logic signed [6:0]     sh_s;
  logic [5:0]            sh;
  logic [55:0]           shifted;
  logic [31:0]           inc32;
  logic [47:0]           inc48;
  logic [PHASE_BITS-1:0] ph_sum;
  logic [15:0]           p16, q16;
  logic [16:0]           d16;
  logic signed [19:0]    tri_w;
  logic signed [17:0]    tri_v;
  logic signed [34:0]    mix_sum;
  logic signed [16:0]    off2;
  logic signed [20:0]    v;
  logic signed [23:0]    l5, lvl;

  assign chan_wide = CW'(in_chan);
  assign addr_in   = chan_wide[AW-1:0];

  assign status.chan_oor = (int'(chan_q) >= NUM_CHANNELS);
  assign res_chan        = chan_q;
  assign res_level       = level;

  always_comb begin
    pitch_sum = 17'(cfg.base_rate) + 17'(gprod >>> 15);
    if (pitch_sum > PITCH_MAX) begin
      pitch_c = PITCH_MAX;
    end else if (pitch_sum < PITCH_MIN) begin
      pitch_c = PITCH_MIN;
    end else begin
      pitch_c = pitch_sum;
    end

    hprod  = 41'(acc) * 41'(frac);
    hround = (hprod + 41'd512) >> 10;

    // right shift by 30 - ip, ip in -20..20
    sh_s    = 7'sd30 - 7'(ip);
    sh      = sh_s[5:0];
    shifted = iprod >> sh;
    inc32   = (shifted > 56'(HALF_CYCLE)) ? HALF_CYCLE : shifted[31:0];
    inc48   = {inc32, 16'd0} >> (48 - PHASE_BITS);

    ph_sum = (rd_vld ? rd_phase : '0) + inc;

    p16   = phase[PHASE_BITS-1 -: 16];
    q16   = p16 + 16'd16384;
    d16   = q16[15] ? (17'd65536 - 17'(q16)) : 17'(q16);
    tri_w = $signed({1'b0, d16, 2'b00}) - 20'sd65536;
    tri_v = tri_w[17:0];

    mix_sum = (sq_neg ? -SQ_TERM : SQ_TERM) + 35'(tri_prod) + MIX_ROUND;

    off2 = $signed({cfg.wave_offset, 1'b0});
    v    = 21'(sprod >>> 16) + 21'(off2);
    l5   = (24'(v) <<< 2) + 24'(v) + 24'sd32;
    lvl  = l5 >>> 6;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      chan_q <= in_chan;
      cv_q   <= in_cv;
      addr_q <= addr_in;
      level  <= '0;
    end
    case (cmd.op)
      OP_PITCH: begin
        gprod <= 31'(cv_q) * 31'(cfg.cv_gain);
      end
      OP_CLAMP: begin
        ip   <= 6'(pitch_c >>> 10);
        frac <= pitch_c[9:0];
        acc  <= horner_coef(cmd.coef_sel);
      end
      OP_HORNER: begin
        acc <= horner_coef(cmd.coef_sel) + hround[30:0];
      end
      OP_INC: begin
        iprod <= 56'(cfg.hz_step) * 56'(acc);
      end
      OP_SHIFT: begin
        inc <= inc48[PHASE_BITS-1:0];
      end
      OP_PHASE: begin
        phase <= ph_sum;
      end
      OP_TRI: begin
        sq_neg   <= p16[15];
        tri_prod <= 34'(tri_v) * TRI_GAIN;
      end
      OP_MIX: begin
        mix <= mix_sum[33:16];
      end
      OP_SCALE: begin
        sprod <= 36'(mix) * 36'($signed({1'b0, cfg.wave_scale}));
      end
      OP_LEVEL: begin
        if (lvl > LVL_MAX) begin
          level <= LVL_MAX[LEVEL_W-1:0];
        end else if (lvl < LVL_MIN) begin
          level <= LVL_MIN[LEVEL_W-1:0];
        end else begin
          level <= lvl[LEVEL_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // phase memory: one read at accept, one write per in-range item
  always_ff @(posedge clk) begin
    if (cmd.op == OP_PHASE) begin
      mem[addr_q] <= ph_sum;
    end
    if (cmd.load) begin
      rd_phase <= mem[addr_in];
      rd_vld   <= vld[addr_in];
    end
  end

  // entry not yet written reads as zero phase
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (cmd.op == OP_PHASE) begin
      vld[addr_q] <= 1'b1;
    end
  end

endmodule

// ===== bench/poly_trapezoid_lfo_core_tb.sv =====
// Self-checking testbench for the polyphonic trapezoid LFO core.
`timescale 1ns / 100ps

module poly_trapezoid_lfo_core_tb
  import ptlfo_pkg::*;
();

  localparam int LFO_CHANNELS = 16;
  localparam longint PITCH_LIM = 20480;

  typedef struct {
    logic [CHAN_W-1:0]         chan;
    logic signed [LEVEL_W-1:0] level;
  } tick_result_t;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [23:0]      s_tdata;    // chan[3:0], rate_cv[18:4], zero pad
  logic             m_tvalid;
  logic             m_tready;
  logic [23:0]      m_tdata;    // out_chan[3:0], out_level[18:4], zero pad
  logic             cfg_valid;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  // shadow of the block: register file and per-channel phase accumulators
  cfg_t         lfo_cfg;
  logic [31:0]  chan_phase_m [LFO_CHANNELS];
  tick_result_t expected_levels [$];
  int           mismatch_count;
  int           hold_off_req;
  int           drain_cycles;
  bit           idle_on;

  poly_trapezoid_lfo_core #(
    .NUM_CHANNELS(LFO_CHANNELS),
    .PHASE_BITS  (32)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Advance one channel's phase by 2^pitch Hz and return its output level.
  function automatic logic signed [LEVEL_W-1:0] advance_channel_level(
      input logic [CHAN_W-1:0] ch, input logic signed [CV_W-1:0] cv);
    longint pitch, ip, p16, q16, d16, sq, tri_w, mix, v, lvl;
    longint unsigned f, acc, mant, inc;
    logic [31:0] ph;
    if (ch >= LFO_CHANNELS) return '0;
    pitch = longint'($signed(lfo_cfg.base_rate))
          + ((longint'(cv) * longint'($signed(lfo_cfg.cv_gain))) >>> 15);
    if (pitch > PITCH_LIM) pitch = PITCH_LIM;
    if (pitch < -PITCH_LIM) pitch = -PITCH_LIM;
    ip = pitch >>> 10;
    f = pitch - ip * 1024;
    // 2^(f/1024) in Q1.30, Horner steps round half up
    acc = 64'd2016026;
    acc = 64'd9652230 + ((acc * f + 64'd512) >> 10);
    acc = 64'd59943043 + ((acc * f + 64'd512) >> 10);
    acc = 64'd257862976 + ((acc * f + 64'd512) >> 10);
    acc = 64'd744267442 + ((acc * f + 64'd512) >> 10);
    mant = (64'd1 << 30) + ((acc * f + 64'd512) >> 10);
    inc = (longint'(lfo_cfg.hz_step) * mant) >> int'(30 - ip);
    if (inc > 64'h8000_0000) inc = 64'h8000_0000;
    ph = chan_phase_m[ch] + inc[31:0];
    chan_phase_m[ch] = ph;
    p16 = longint'(ph[31:16]);
    sq = (p16 < 32768) ? 65536 : -65536;
    q16 = (p16 + 16384) & 65535;
    d16 = (q16 < 32768) ? q16 : 65536 - q16;
    tri_w = 4 * d16 - 65536;
    mix = (19661 * sq + 45875 * tri_w + 32768) >>> 16;
    v = ((mix * longint'(lfo_cfg.wave_scale)) >>> 16)
      + 2 * longint'($signed(lfo_cfg.wave_offset));
    lvl = (5 * v + 32) >>> 6;
    if (lvl > 16383) lvl = 16383;
    if (lvl < -16384) lvl = -16384;
    return lvl[LEVEL_W-1:0];
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.base_rate   = ($urandom_range(0, 7) == 0) ? 15'($urandom)
                                                : 15'(int'($urandom_range(0, 18432)) - 8192);
    c.cv_gain     = 16'($urandom);
    c.wave_scale  = ($urandom_range(0, 7) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
    c.wave_offset = 16'($urandom);
    c.hz_step     = ($urandom_range(0, 7) == 0) ? 25'($urandom)
                                                : 25'($urandom_range(1, 1 << $urandom_range(0, 24)));
    return c;
  endfunction

  function automatic logic signed [CV_W-1:0] random_cv();
    if ($urandom_range(0, 5) == 0) return CV_W'($urandom);
    return CV_W'(int'($urandom_range(0, 20480)) - 10240);
  endfunction

  // Write all five registers; only called with the core idle.
  task automatic load_regs(input cfg_t c);
    logic [CFG_W-1:0] word;
    for (int i = REG_BASE_RATE; i <= REG_HZ_STEP; i++) begin
      case (reg_idx_t'(i))
        REG_BASE_RATE:   word = CFG_W'(c.base_rate);
        REG_CV_GAIN:     word = CFG_W'(c.cv_gain);
        REG_WAVE_SCALE:  word = CFG_W'(c.wave_scale);
        REG_WAVE_OFFSET: word = CFG_W'(c.wave_offset);
        default:         word = CFG_W'(c.hz_step);
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= reg_idx_t'(i);
      cfg_data  <= word;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    lfo_cfg = c;
  endtask

  // Offer one tick word; valid stays high afterwards unless a gap follows.
  task automatic send_tick(input logic [CHAN_W-1:0] ch, input logic signed [CV_W-1:0] cv);
    tick_result_t r;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, cv, ch};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r.chan  = ch;
    r.level = advance_channel_level(ch, cv);
    expected_levels.push_back(r);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_levels.size() != 0);
  endtask

  task automatic check_word(input logic [23:0] w);
    tick_result_t want;
    if (expected_levels.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 50)
        $display("%0t ns: unexpected word, actual chan %0d level %0d",
                 $time, w[3:0], $signed(w[18:4]));
      return;
    end
    want = expected_levels.pop_front();
    if (w[3:0] !== want.chan || w[18:4] !== want.level) begin
      mismatch_count++;
      if (mismatch_count <= 50)
        $display("%0t ns: chan expected %0d actual %0d, level expected %0d actual %0d",
                 $time, want.chan, w[3:0], want.level, $signed(w[18:4]));
    end
  endtask

  // Output side: checks each accepted word and stalls ready at random or on request.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) check_word(m_tdata);
      if (hold_off_req > 0) begin
        stall_left = hold_off_req;
        hold_off_req = 0;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 10);
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Reset register values, phases start at zero.
  task automatic test_reset_defaults();
    send_tick(4'd0, 15'h4000);
    send_tick(4'd15, 15'h3FFF);
    send_tick(4'd0, 15'sd0);
    send_tick(4'd7, -15'sd10240);
    send_tick(4'd15, 15'sd10240);
    send_tick(4'd0, 15'sd1);
    wait_drained();
  endtask

  task automatic test_rate_extremes();
    // pitch clamped high, increment saturates at half a cycle, widest scale
    load_regs(cfg_t'{15'sd10240, 16'h8000, 17'h1FFFF, 16'sd32767, 25'h1FFFFFF});
    send_tick(4'd3, 15'h4000);
    send_tick(4'd3, 15'h3FFF);
    send_tick(4'd3, 15'sd0);
    send_tick(4'd3, -15'sd10240);
    send_tick(4'd12, 15'sd10240);
    send_tick(4'd3, 15'h4000);
    wait_drained();
    // pitch clamped low, zero scale, most negative offset
    load_regs(cfg_t'{15'h4000, 16'sd32767, 17'd0, 16'h8000, 25'd16777216});
    send_tick(4'd5, 15'h4000);
    send_tick(4'd5, 15'h3FFF);
    send_tick(4'd10, 15'sd10240);
    send_tick(4'd5, -15'sd10240);
    wait_drained();
    // zero hz_step: phases hold still
    load_regs(cfg_t'{15'sd0, 16'sd0, 17'd65536, 16'sd0, 25'd0});
    send_tick(4'd3, 15'sd0);
    send_tick(4'd3, 15'h3FFF);
    send_tick(4'd0, 15'h4000);
    send_tick(4'd10, 15'sd77);
    wait_drained();
  endtask

  // Long output stall while ticks keep coming, then a full pause on input.
  task automatic test_input_stall();
    bit saved;
    saved = idle_on;
    idle_on = 0;
    load_regs(cfg_t'{15'sd6000, 16'sd12000, 17'd40000, 16'sd5000, 25'd2000000});
    hold_off_req = 300;
    for (int k = 0; k < 24; k++) send_tick(4'($urandom), random_cv());
    wait_drained();
    idle_on = saved;
  endtask

  task automatic test_random_ticks(input int phases, input int per_phase);
    for (int p = 0; p < phases; p++) begin
      load_regs(random_cfg());
      for (int k = 0; k < per_phase; k++) send_tick(4'($urandom), random_cv());
      wait_drained();
    end
  endtask

  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_BASE_RATE;
    cfg_data  <= '0;
    mismatch_count = 0;
    hold_off_req = 0;
    idle_on = 1;
    lfo_cfg = '{BASE_RATE_RST, CV_GAIN_RST, WAVE_SCALE_RST, WAVE_OFFSET_RST, HZ_STEP_RST};
    for (int c = 0; c < LFO_CHANNELS; c++) chan_phase_m[c] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_rate_extremes();
    test_input_stall();
    test_random_ticks(6, 125);
    idle_on = 0;
    test_random_ticks(1, 150);

    drain_cycles = 0;
    while (expected_levels.size() != 0 && drain_cycles < 20000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (40) @(posedge clk);
    if (expected_levels.size() != 0) begin
      mismatch_count += expected_levels.size();
      $display("%0t ns: %0d expected words never arrived", $time, expected_levels.size());
    end
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== poly_trapezoid_lfo_core.f =====
+incdir+rtl
rtl/ptlfo_pkg.sv
rtl/ptlfo_ctrl.sv
rtl/ptlfo_dpath.sv
rtl/poly_trapezoid_lfo_core.sv
bench/poly_trapezoid_lfo_core_tb.sv
